// ===== rtl/sliding_window_median_core_defines.svh =====
// ----------------------------------------------------------------------------
// Sliding window median: assertion macros
// Shared property wrappers for the checker, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_CORE_DEFINES_SVH

// Checked only outside reset
`define SWM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define SWM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window median package
// Field widths and default sizing shared by the core and its checker.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int SWM_MAX_WINDOW   = 16;
    localparam int SWM_RESET_WINDOW = 5;
    localparam int SAMPLE_W         = 16;
    localparam int SIZE_W           = 5;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [SIZE_W-1:0]   t_size;

endpackage

// ===== rtl/sliding_window_median_core.sv =====
// ----------------------------------------------------------------------------
// Sliding window median core
// Running median of the last window_size unsigned 16-bit samples.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one sample word, taken at an edge
// with i_valid high and o_stall low. Output channel: o_valid / i_stall carry
// the median and the fill count; the word holds while i_stall is high.
// The window is kept sorted in one single-port-read memory of {value, age}
// entries. A sample that finds the window full first costs a scan of N reads
// that removes the oldest entry and closes the gap, then a downward walk of
// at most N - 1 reads shifts larger entries up before the new one is placed.
// Here N is the window size. A sample passes the start step, the drop scan
// when the window is full, the walk when it holds entries, placement, the
// median read and the output latch. The next sample can be taken in the
// cycle after the previous result is registered; one sample is in flight at a
// time and o_stall stays high while it is worked on.
// The output register lets the next sample enter while a result waits; a
// finished median waits in its final step if the previous word is stalled.
// Writing i_cfg_we empties the window and sets the size (0 reads as 1,
// larger than MAX_WINDOW reads as MAX_WINDOW); only write it while idle.
// Reset (i_rst_n low, synchronous) empties the window, sets the size to 5
// (clamped) and drops any pending output word. No memory clearing is needed.
// ----------------------------------------------------------------------------
module sliding_window_median_core #(
    parameter int MAX_WINDOW = swm_pkg::SWM_MAX_WINDOW
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  swm_pkg::t_sample i_sample,
    output logic             o_valid,
    input  logic             i_stall,
    output swm_pkg::t_sample o_median,
    output swm_pkg::t_size   o_fill_count,
    input  logic             i_cfg_we,
    input  swm_pkg::t_size   i_cfg_data
);
    import swm_pkg::*;

    localparam int IW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int AW  = IW;
    localparam int CWR = $clog2(MAX_WINDOW + 1);
    localparam int CW  = (CWR > SIZE_W) ? CWR : SIZE_W;
    localparam int EW  = SAMPLE_W + AW;

    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_WINDOW);
    localparam logic [CW-1:0] RESET_WS = (SWM_RESET_WINDOW > MAX_WINDOW) ?
                                         CW'(MAX_WINDOW) : CW'(SWM_RESET_WINDOW);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_DROP  = 3'd2;
    localparam logic [2:0] S_INS   = 3'd3;
    localparam logic [2:0] S_PLACE = 3'd4;
    localparam logic [2:0] S_MED   = 3'd5;
    localparam logic [2:0] S_LATCH = 3'd6;

    logic [EW-1:0] r_mem [MAX_WINDOW];
    logic [EW-1:0] r_rdata;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_held, n_held;
    logic [CW-1:0] r_ws, n_ws;
    logic [CW-1:0] r_ra, n_ra;
    logic [CW-1:0] r_di, n_di;
    logic [CW-1:0] r_wpos, n_wpos;
    logic          r_dv, n_dv;
    logic          r_iss, n_iss;
    logic          r_found, n_found;
    t_sample       r_sample, n_sample;
    logic          r_out_valid, n_out_valid;
    t_sample       r_out_median, n_out_median;
    t_size         r_out_count, n_out_count;

    logic          w_we;
    logic [IW-1:0] w_wa;
    logic [EW-1:0] w_wd;
    logic [CW-1:0] w_cfg_ext;
    logic [CW-1:0] w_cfg_ws;
    logic [CW-1:0] w_held_dn;
    logic [CW-1:0] w_held_up;
    logic [CW-1:0] w_di_dn;
    logic [CW-1:0] w_di_up;
    t_sample       w_rd_value;
    logic [AW-1:0] w_rd_age;

    assign w_cfg_ext  = CW'(i_cfg_data);
    assign w_cfg_ws   = (w_cfg_ext == '0) ? CW'(1) :
                        ((w_cfg_ext > MAX_CNT) ? MAX_CNT : w_cfg_ext);
    assign w_held_dn  = r_held - CW'(1);
    assign w_held_up  = r_held + CW'(1);
    assign w_di_dn    = r_di - CW'(1);
    assign w_di_up    = r_di + CW'(1);
    assign w_rd_value = r_rdata[EW-1:AW];
    assign w_rd_age   = r_rdata[AW-1:0];

    always_comb begin
        n_state      = r_state;
        n_held       = r_held;
        n_ws         = r_ws;
        n_ra         = r_ra;
        n_di         = r_di;
        n_wpos       = r_wpos;
        n_dv         = 1'b0;
        n_iss        = r_iss;
        n_found      = r_found;
        n_sample     = r_sample;
        n_out_valid  = r_out_valid;
        n_out_median = r_out_median;
        n_out_count  = r_out_count;
        w_we         = 1'b0;
        w_wa         = r_di[IW-1:0];
        w_wd         = r_rdata;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sample = i_sample;
                    n_state  = S_START;
                end
            end
            S_START: begin
                if (r_held >= r_ws) begin
                    n_state = S_DROP;
                    n_ra    = '0;
                    n_iss   = 1'b1;
                    n_found = 1'b0;
                end else if (r_held == '0) begin
                    n_wpos  = '0;
                    n_state = S_PLACE;
                end else begin
                    n_state = S_INS;
                    n_ra    = w_held_dn;
                    n_iss   = 1'b1;
                end
            end
            S_DROP: begin
                // reads run one entry ahead of the write-back
                if (r_iss) begin
                    n_di = r_ra;
                    n_dv = 1'b1;
                    if (r_ra == w_held_dn) begin
                        n_iss = 1'b0;
                    end else begin
                        n_ra = r_ra + CW'(1);
                    end
                end
                if (r_dv) begin
                    if (!r_found && (w_rd_age == '0)) begin
                        n_found = 1'b1;
                    end else begin
                        w_we = 1'b1;
                        w_wa = r_found ? w_di_dn[IW-1:0] : r_di[IW-1:0];
                        w_wd = {w_rd_value, w_rd_age - AW'(1)};
                    end
                    if (r_di == w_held_dn) begin
                        n_held  = w_held_dn;
                        n_state = S_START;
                    end
                end
            end
            S_INS: begin
                // walk down from the top, moving larger entries up one slot
                if (r_iss) begin
                    n_di = r_ra;
                    n_dv = 1'b1;
                    if (r_ra == '0) begin
                        n_iss = 1'b0;
                    end else begin
                        n_ra = r_ra - CW'(1);
                    end
                end
                if (r_dv) begin
                    if (w_rd_value > r_sample) begin
                        w_we = 1'b1;
                        w_wa = w_di_up[IW-1:0];
                        w_wd = r_rdata;
                        if (r_di == '0) begin
                            n_wpos  = '0;
                            n_iss   = 1'b0;
                            n_state = S_PLACE;
                        end
                    end else begin
                        n_wpos  = w_di_up;
                        n_iss   = 1'b0;
                        n_state = S_PLACE;
                    end
                end
            end
            S_PLACE: begin
                w_we    = 1'b1;
                w_wa    = r_wpos[IW-1:0];
                w_wd    = {r_sample, r_held[AW-1:0]};
                n_held  = w_held_up;
                n_ra    = w_held_up >> 1;
                n_state = S_MED;
            end
            S_MED: begin
                n_state = S_LATCH;
            end
            S_LATCH: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_median = w_rd_value;
                    n_out_count  = r_held[SIZE_W-1:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_ws   = w_cfg_ws;
            n_held = '0;
        end
    end

    // window memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rdata <= r_mem[r_ra[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_ws        <= RESET_WS;
            r_dv        <= 1'b0;
            r_iss       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_ws        <= n_ws;
            r_dv        <= n_dv;
            r_iss       <= n_iss;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ra         <= n_ra;
        r_di         <= n_di;
        r_wpos       <= n_wpos;
        r_found      <= n_found;
        r_sample     <= n_sample;
        r_out_median <= n_out_median;
        r_out_count  <= n_out_count;
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_median     = r_out_median;
    assign o_fill_count = r_out_count;

endmodule

// ===== rtl/swm_checker.sv =====
// ----------------------------------------------------------------------------
// Sliding window median checker
// Port-level checks on the core, attached by bind.
// ----------------------------------------------------------------------------
`include "sliding_window_median_core_defines.svh"

module swm_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input swm_pkg::t_sample i_sample,
    input logic             o_valid,
    input logic             i_stall,
    input swm_pkg::t_sample o_median,
    input swm_pkg::t_size   o_fill_count,
    input logic             i_cfg_we,
    input swm_pkg::t_size   i_cfg_data
);
    import swm_pkg::*;

    // a stalled result word stays put
    `SWM_ASSERT(a_out_hold, (o_valid && i_stall) |=> (o_valid && $stable(o_median) && $stable(o_fill_count)), "output word changed while stalled")

    // a result always holds at least the new sample
    `SWM_ASSERT(a_count_nonzero, o_valid |-> (o_fill_count != '0), "result with empty window")

    // one sample at a time: an accepted word closes the input
    `SWM_ASSERT(a_busy_after_accept, (i_valid && !o_stall) |=> o_stall, "input open right after accept")

    // a fresh result only ever follows the block finishing its work
    `SWM_ASSERT(a_result_from_busy, (o_valid && !$past(o_valid)) |-> $past(o_stall), "result appeared while idle")

    // reset leaves the block idle with nothing to deliver
    `SWM_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!o_valid && !o_stall), "not idle after reset")

endmodule

bind sliding_window_median_core swm_checker u_swm_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median core testbench
// Drives sample words through the core, predicts each median and fill count
// from a sorted copy of the window, and checks every output word in order.
// Runs directed corner cases, random window sizes with random idling on both
// sides, a long output hold-off and a quiet tail.
// ----------------------------------------------------------------------------
module tb;
    import swm_pkg::*;

    localparam int MAXW         = SWM_MAX_WINDOW;
    localparam int CLK_HALF     = 6;
    localparam int LIMIT_CYCLES = 600000;
    localparam int TAIL_CYCLES  = 2 * MAXW + 17;
    localparam int RANDOM_ITEMS = 1350;

    typedef struct packed {
        t_sample median;
        t_size   fill;
    } t_median_word;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_stall;
    t_sample i_sample;
    logic    o_valid;
    logic    i_stall;
    t_sample o_median;
    t_size   o_fill_count;
    logic    i_cfg_we;
    t_size   i_cfg_data;

    // predicted window: sorted values with arrival ranks
    t_sample      win_vals [MAXW];
    logic [3:0]   win_ages [MAXW];
    int           win_held;
    int           win_size;

    t_median_word pending_results[$];
    int           mismatch_count = 0;
    int           samples_sent   = 0;
    int           cycle_count    = 0;

    int           send_idle_pct    = 0;
    int           recv_idle_pct    = 0;
    int           result_hold_left = 0;
    int           stall_burst_left = 0;
    bit           quiet_tail       = 1'b0;

    sliding_window_median_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_median     (o_median),
        .o_fill_count (o_fill_count),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("[sliding_window_median_core] ERROR");
            $finish;
        end
    end

    function automatic int clamp_window(input int v);
        if (v < 1)
            return 1;
        if (v > MAXW)
            return MAXW;
        return v;
    endfunction

    // Slide the predicted window by one sample and give the word it yields
    task automatic advance_window(input t_sample s, output t_median_word word);
        int  i;
        int  pos;
        bit  found;
        bit  stuck;
        stuck = 1'b0;
        while (win_held >= win_size && win_held > 0 && !stuck) begin
            found = 1'b0;
            pos   = 0;
            for (i = 0; i < win_held; i++) begin
                if (!found && win_ages[i] == 4'd0) begin
                    pos   = i;
                    found = 1'b1;
                end
            end
            if (!found) begin
                stuck = 1'b1;
            end else begin
                for (i = pos; i + 1 < win_held; i++) begin
                    win_vals[i] = win_vals[i + 1];
                    win_ages[i] = win_ages[i + 1];
                end
                win_held--;
                for (i = 0; i < win_held; i++) begin
                    if (win_ages[i] > 4'd0)
                        win_ages[i] = win_ages[i] - 4'd1;
                end
            end
        end
        if (win_held < MAXW) begin
            // equal values stay ahead of the newcomer
            pos = win_held;
            while (pos > 0 && win_vals[pos - 1] > s) begin
                win_vals[pos] = win_vals[pos - 1];
                win_ages[pos] = win_ages[pos - 1];
                pos--;
            end
            win_vals[pos] = s;
            win_ages[pos] = win_held[3:0];
            win_held++;
        end
        pos = win_held / 2;
        if (pos >= MAXW)
            pos = MAXW - 1;
        word.median = win_vals[pos];
        word.fill   = win_held[SIZE_W-1:0];
    endtask

    // Offer one sample word and hold it until taken; valid stays high after
    task automatic send_sample(input t_sample s);
        t_median_word word;
        int           gap;
        if (!quiet_tail && send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 11);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_valid  <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        advance_window(s, word);
        pending_results.push_back(word);
        samples_sent++;
    endtask

    // Stop offering and wait for every outstanding median
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_window(input t_size v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        win_size = clamp_window(int'(v));
        win_held = 0;
    endtask

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 4))
            0: return t_sample'($urandom_range(0, 7));
            1: begin
                case ($urandom_range(0, 3))
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    2: return 16'h0001;
                    default: return 16'hFFFE;
                endcase
            end
            2: return t_sample'(16'h8000 + $urandom_range(0, 6) - 3);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic t_size pick_window_reg();
        case ($urandom_range(0, 7))
            0: return t_size'(0);
            1: return t_size'($urandom_range(17, 31));
            2: return t_size'(MAXW);
            3: return t_size'(1);
            4: return t_size'($urandom_range(2, 4));
            default: return t_size'($urandom_range(1, MAXW));
        endcase
    endfunction

    // Reset size, wrapping the window of five with extreme values
    task automatic test_reset_window();
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h0001);
        send_sample(16'hFFFE);
        send_sample(16'h1234);
    endtask

    // Sizes outside 1..MAX_WINDOW, all register bits high and low
    task automatic test_size_clamp();
        write_window(t_size'(0));
        send_sample(16'hAAAA);
        send_sample(16'h5555);
        write_window(t_size'(31));
        send_sample(16'h0F0F);
        send_sample(16'hF0F0);
        send_sample(16'h0F0F);
        write_window(t_size'(17));
        send_sample(16'h4321);
    endtask

    // Duplicates: the oldest of equal values must be the one removed
    task automatic test_equal_values();
        write_window(t_size'(3));
        send_sample(16'd7);
        send_sample(16'd7);
        send_sample(16'd3);
        send_sample(16'd7);
        send_sample(16'd7);
        send_sample(16'd7);
        send_sample(16'd9);
        write_window(t_size'(2));
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h0000);
    endtask

    task automatic test_random_windows();
        int n;
        int k;
        int target;
        target = samples_sent + RANDOM_ITEMS;
        while (samples_sent < target) begin
            case ($urandom_range(0, 3))
                0: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                1: begin
                    send_idle_pct = 10;
                    recv_idle_pct = 10;
                end
                2: begin
                    send_idle_pct = 40;
                    recv_idle_pct = 5;
                end
                default: begin
                    send_idle_pct = 5;
                    recv_idle_pct = 40;
                end
            endcase
            write_window(pick_window_reg());
            n = $urandom_range(10, 60);
            for (k = 0; k < n; k++) begin
                send_sample(pick_sample());
                // occasional pause with all results home, window kept
                if ($urandom_range(0, 99) == 0)
                    drain();
            end
        end
    endtask

    // Hold the output for a long stretch while samples keep coming
    task automatic test_backpressure();
        int k;
        write_window(t_size'(MAXW));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge i_clk);
        result_hold_left = 300;
        for (k = 0; k < 25; k++)
            send_sample(pick_sample());
        drain();
        for (k = 0; k < 5; k++)
            send_sample(pick_sample());
    endtask

    task automatic test_quiet_tail();
        int k;
        write_window(t_size'($urandom_range(1, MAXW)));
        quiet_tail = 1'b1;
        for (k = 0; k < 100; k++)
            send_sample(pick_sample());
    endtask

    // output side: random stall bursts plus the long hold-off
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (result_hold_left > 0) begin
                i_stall <= 1'b1;
                result_hold_left--;
            end else if (stall_burst_left > 0) begin
                i_stall <= 1'b1;
                stall_burst_left--;
            end else if (!quiet_tail && recv_idle_pct > 0
                         && $urandom_range(0, 99) < recv_idle_pct) begin
                i_stall <= 1'b1;
                stall_burst_left = $urandom_range(1, 11) - 1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_median_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected word: median %h fill %0d", o_median, o_fill_count);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_median !== want.median || o_fill_count !== want.fill) begin
                    if (mismatch_count < 10)
                        $display("mismatch: median %h fill %0d, expected median %h fill %0d",
                                 o_median, o_fill_count, want.median, want.fill);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_sample   = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        foreach (win_vals[i]) begin
            win_vals[i] = '0;
            win_ages[i] = '0;
        end
        win_held = 0;
        win_size = clamp_window(SWM_RESET_WINDOW);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_window();
        test_size_clamp();
        test_equal_values();
        test_random_windows();
        test_backpressure();
        test_quiet_tail();

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("[sliding_window_median_core] OK");
        end else begin
            $display("[sliding_window_median_core] ERROR");
        end
        $finish;
    end

endmodule
